// File: rtl/sbfh_pkg.sv
`timescale 1ns / 1ps
// shared constants for the segment/box first-hit unit
// no dependencies

package sbfh_pkg;

  localparam int COORD_WIDTH_DEF    = 24;
  localparam int TIME_FRAC_BITS_DEF = 16;

  localparam int SIDE_W = 3;

  localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd4;

endpackage

// File: rtl/sbfh_edge.sv
`timescale 1ns / 1ps
// one box edge: crossing test with registered products and a pipelined divider
// depends on sbfh_pkg

module sbfh_edge
  import sbfh_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [COORD_WIDTH:0]      plane,
  input  logic signed [COORD_WIDTH-1:0]    s_perp,
  input  logic signed [COORD_WIDTH-1:0]    d_perp,
  input  logic signed [COORD_WIDTH:0]      lo,
  input  logic signed [COORD_WIDTH:0]      hi,
  input  logic signed [COORD_WIDTH-1:0]    s_par,
  input  logic signed [COORD_WIDTH-1:0]    d_par,
  input  logic                             span_nz,
  output logic                             hit,
  output logic [TIME_FRAC_BITS:0]          t
);

  localparam int W = COORD_WIDTH;
  localparam int F = TIME_FRAC_BITS;
  localparam logic signed [W+1:0] CLAMP_HI = $signed({3'b001, {(W-2){1'b0}}, 1'b1});
  localparam logic signed [W+1:0] CLAMP_LO = -CLAMP_HI;

  // stage 1: numerator, |denominator|, clamped span
  logic signed [W+1:0] n_raw;
  logic signed [W+2:0] n_ext, n_s, den_cmp;
  logic signed [W:0]   d_ext, den_mag;
  logic signed [W+1:0] lo_d, hi_d;
  logic signed [W:0]   lo_c, hi_c;
  logic                dneg, ok1_nxt;

  always_comb begin
    n_raw   = (W+2)'(plane) - (W+2)'(s_perp);
    dneg    = d_perp[W-1];
    n_ext   = (W+3)'(n_raw);
    n_s     = dneg ? -n_ext : n_ext;
    d_ext   = (W+1)'(d_perp);
    den_mag = dneg ? -d_ext : d_ext;
    den_cmp = $signed({3'b000, den_mag[W-1:0]});
    ok1_nxt = (d_perp != '0) && span_nz && !n_s[W+2] && (n_s <= den_cmp);
    lo_d    = (W+2)'(lo) - (W+2)'(s_par);
    hi_d    = (W+2)'(hi) - (W+2)'(s_par);
    if (lo_d > CLAMP_HI) begin
      lo_c = CLAMP_HI[W:0];
    end else if (lo_d < CLAMP_LO) begin
      lo_c = CLAMP_LO[W:0];
    end else begin
      lo_c = lo_d[W:0];
    end
    if (hi_d > CLAMP_HI) begin
      hi_c = CLAMP_HI[W:0];
    end else if (hi_d < CLAMP_LO) begin
      hi_c = CLAMP_LO[W:0];
    end else begin
      hi_c = hi_d[W:0];
    end
  end

  logic [W-1:0]        n1_r, den1_r;
  logic signed [W-1:0] dp1_r;
  logic signed [W:0]   lo1_r, hi1_r;
  logic                ok1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n_s[W-1:0];
      den1_r <= den_mag[W-1:0];
      dp1_r  <= d_par;
      lo1_r  <= lo_c;
      hi1_r  <= hi_c;
      ok1_r  <= ok1_nxt;
    end
  end

  // stage 2: products
  logic signed [2*W+1:0] prod2_r, a2_r, b2_r;
  logic [W-1:0]          n2_r, den2_r;
  logic                  ok2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r <= $signed({1'b0, n1_r}) * dp1_r;
      a2_r    <= lo1_r * $signed({1'b0, den1_r});
      b2_r    <= hi1_r * $signed({1'b0, den1_r});
      n2_r    <= n1_r;
      den2_r  <= den1_r;
      ok2_r   <= ok1_r;
    end
  end

  // stage 3 feeds divider slot 0; slots 1..F+1 each resolve one quotient bit
  logic [W:0]   rem_r [0:F+1];
  logic [W-1:0] dvs_r [0:F+1];
  logic [F:0]   quo_r [0:F+1];
  logic         ok_r  [0:F+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, n2_r};
      dvs_r[0] <= den2_r;
      quo_r[0] <= '0;
      ok_r[0]  <= ok2_r && !(prod2_r < a2_r) && !(prod2_r > b2_r);
    end
  end

  for (genvar k = 1; k <= F + 1; k++) begin : g_div
    logic         ge;
    logic [W:0]   diff;
    logic [W:0]   rem_nxt;
    always_comb begin
      ge      = rem_r[k-1] >= {1'b0, dvs_r[k-1]};
      diff    = ge ? rem_r[k-1] - {1'b0, dvs_r[k-1]} : rem_r[k-1];
      rem_nxt = {diff[W-1:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        dvs_r[k] <= dvs_r[k-1];
        quo_r[k] <= {quo_r[k-1][F-1:0], ge};
        ok_r[k]  <= ok_r[k-1];
      end
    end
  end

  assign hit = ok_r[F+1];
  assign t   = quo_r[F+1];

endmodule

// File: rtl/segment_box_first_hit_unit.sv
`timescale 1ns / 1ps
// top level of the segment/box first-hit unit
// depends on sbfh_pkg and sbfh_edge

// Finds where a 2D segment first crosses the edges of an axis-aligned box.
// One transaction per clock in each direction while the output is not stalled;
// a result passes the edge pipelines, whose divider resolves one time bit per
// stage, and then the output register.
// The whole pipeline holds while the output waits, so nothing is dropped.

module segment_box_first_hit_unit
  import sbfh_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
  localparam int IN_BITS  = 6 * COORD_WIDTH + 2 * (COORD_WIDTH - 2),
  localparam int IN_W     = (IN_BITS + 7) / 8 * 8,
  localparam int OUT_BITS = 1 + (TIME_FRAC_BITS + 1) + SIDE_W,
  localparam int OUT_W    = (OUT_BITS + 7) / 8 * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // seg_start_x, seg_start_y, seg_delta_x, seg_delta_y, box_center_x,
  // box_center_y, box_half_x, box_half_y
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, hit_time, side
  output logic [OUT_W-1:0] out_tdata
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = TIME_FRAC_BITS;
  localparam int LAT = F + 4;

  logic signed [W-1:0] sx, sy, dx, dy, cx, cy;
  logic [W-3:0]        hx, hy;
  logic signed [W:0]   xl, xr, yb, yt;
  logic                en;

  assign sx = in_tdata[W-1:0];
  assign sy = in_tdata[2*W-1:W];
  assign dx = in_tdata[3*W-1:2*W];
  assign dy = in_tdata[4*W-1:3*W];
  assign cx = in_tdata[5*W-1:4*W];
  assign cy = in_tdata[6*W-1:5*W];
  assign hx = in_tdata[7*W-3:6*W];
  assign hy = in_tdata[8*W-5:7*W-2];

  assign xl = (W+1)'(cx) - $signed({3'b000, hx});
  assign xr = (W+1)'(cx) + $signed({3'b000, hx});
  assign yb = (W+1)'(cy) - $signed({3'b000, hy});
  assign yt = (W+1)'(cy) + $signed({3'b000, hy});

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [3:0] e_hit;
  logic [F:0] e_t [0:3];

  sbfh_edge #(.COORD_WIDTH(W), .TIME_FRAC_BITS(F)) u_top (
    .clk, .en, .plane(yt), .s_perp(sy), .d_perp(dy), .lo(xl), .hi(xr),
    .s_par(sx), .d_par(dx), .span_nz(hx != '0), .hit(e_hit[0]), .t(e_t[0]));
  sbfh_edge #(.COORD_WIDTH(W), .TIME_FRAC_BITS(F)) u_bottom (
    .clk, .en, .plane(yb), .s_perp(sy), .d_perp(dy), .lo(xl), .hi(xr),
    .s_par(sx), .d_par(dx), .span_nz(hx != '0), .hit(e_hit[1]), .t(e_t[1]));
  sbfh_edge #(.COORD_WIDTH(W), .TIME_FRAC_BITS(F)) u_left (
    .clk, .en, .plane(xl), .s_perp(sx), .d_perp(dx), .lo(yb), .hi(yt),
    .s_par(sy), .d_par(dy), .span_nz(hy != '0), .hit(e_hit[2]), .t(e_t[2]));
  sbfh_edge #(.COORD_WIDTH(W), .TIME_FRAC_BITS(F)) u_right (
    .clk, .en, .plane(xr), .s_perp(sx), .d_perp(dx), .lo(yb), .hi(yt),
    .s_par(sy), .d_par(dy), .span_nz(hy != '0), .hit(e_hit[3]), .t(e_t[3]));

  // valid bits alongside the edge pipelines
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // earliest time, later edge wins ties
  logic [F:0]        best;
  logic [SIDE_W-1:0] side;

  always_comb begin
    best = {1'b1, {F{1'b0}}};
    side = SIDE_NONE;
    if (e_hit[0] && e_t[0] <= best) begin
      best = e_t[0];
      side = SIDE_TOP;
    end
    if (e_hit[1] && e_t[1] <= best) begin
      best = e_t[1];
      side = SIDE_BOTTOM;
    end
    if (e_hit[2] && e_t[2] <= best) begin
      best = e_t[2];
      side = SIDE_LEFT;
    end
    if (e_hit[3] && e_t[3] <= best) begin
      best = e_t[3];
      side = SIDE_RIGHT;
    end
  end

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({side, best, side != SIDE_NONE});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/sbfh_chk.sv
`timescale 1ns / 1ps
// port-level checks for the segment/box first-hit unit, bound to the top level
// depends on sbfh_pkg

module sbfh_chk
  import sbfh_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
  parameter int OUT_W          = 24
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int F = TIME_FRAC_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [F:0]        o_time;
  logic [SIDE_W-1:0] o_side;

  assign o_time = out_tdata[F+1:1];
  assign o_side = out_tdata[F+1+SIDE_W:F+2];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> o_time == ONE && o_side == SIDE_NONE)
    else $error("miss with time or side set");

  a_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      o_side == SIDE_TOP || o_side == SIDE_BOTTOM ||
      o_side == SIDE_LEFT || o_side == SIDE_RIGHT)
    else $error("hit without a side");

  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_time <= ONE)
    else $error("hit time above one");

endmodule

bind segment_box_first_hit_unit sbfh_chk #(
  .COORD_WIDTH(COORD_WIDTH),
  .TIME_FRAC_BITS(TIME_FRAC_BITS),
  .OUT_W(OUT_W)
) u_sbfh_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// File: test/segment_box_first_hit_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for segment_box_first_hit_unit: random bursty stream in,
// stalling sink out, every result checked against a built-in predictor
// depends on sbfh_pkg and the unit under test

module segment_box_first_hit_unit_tb;
  import sbfh_pkg::*;

  localparam int CW     = 24;
  localparam int HW     = CW - 2;
  localparam int TF     = 16;
  localparam int IN_W   = 192;
  localparam int OUT_W  = 24;
  localparam int NRAND  = 1300;
  localparam longint TIME_ONE = longint'(1) << TF;
  localparam longint CLAMP_LIM = (longint'(1) << (CW - 1)) + 1;

  typedef struct packed {
    logic [HW-1:0] half_y;
    logic [HW-1:0] half_x;
    logic signed [CW-1:0] cen_y;
    logic signed [CW-1:0] cen_x;
    logic signed [CW-1:0] del_y;
    logic signed [CW-1:0] del_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_x;
  } query_t;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [TF:0] t_hit;
    logic hit;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  query_t pending_queries[$];
  answer_t expected_answers[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  segment_box_first_hit_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_coord(longint v);
    if (v > CLAMP_LIM) return CLAMP_LIM;
    if (v < -CLAMP_LIM) return -CLAMP_LIM;
    return v;
  endfunction

  // edge on line perp == plane spanning [lo, hi] along the other axis
  function automatic bit edge_crossing(longint plane, longint s_perp, longint d_perp,
                                       longint lo, longint hi, longint s_par,
                                       longint d_par, output longint t);
    longint num, den;
    num = plane - s_perp;
    den = d_perp;
    t = 0;
    if (den == 0 || hi == lo) return 0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0 || num > den) return 0;
    if (num * d_par < clamp_coord(lo - s_par) * den) return 0;
    if (num * d_par > clamp_coord(hi - s_par) * den) return 0;
    t = (num << TF) / den;
    return 1;
  endfunction

  function automatic answer_t first_hit(query_t q);
    longint sx, sy, dx, dy, xl, xr, yb, yt, t, best;
    answer_t a;
    sx = q.start_x;
    sy = q.start_y;
    dx = q.del_x;
    dy = q.del_y;
    xl = longint'(q.cen_x) - longint'(q.half_x);
    xr = longint'(q.cen_x) + longint'(q.half_x);
    yb = longint'(q.cen_y) - longint'(q.half_y);
    yt = longint'(q.cen_y) + longint'(q.half_y);
    best = TIME_ONE;
    a.side = SIDE_NONE;
    if (edge_crossing(yt, sy, dy, xl, xr, sx, dx, t) && t <= best) begin
      best = t;
      a.side = SIDE_TOP;
    end
    if (edge_crossing(yb, sy, dy, xl, xr, sx, dx, t) && t <= best) begin
      best = t;
      a.side = SIDE_BOTTOM;
    end
    if (edge_crossing(xl, sx, dx, yb, yt, sy, dy, t) && t <= best) begin
      best = t;
      a.side = SIDE_LEFT;
    end
    if (edge_crossing(xr, sx, dx, yb, yt, sy, dy, t) && t <= best) begin
      best = t;
      a.side = SIDE_RIGHT;
    end
    a.hit = (a.side != SIDE_NONE);
    a.t_hit = best[TF:0];
    return a;
  endfunction

  function automatic query_t make_query(longint sx, longint sy, longint dx, longint dy,
                                        longint cx, longint cy, longint hx, longint hy);
    query_t q;
    q.start_x = sx[CW-1:0];
    q.start_y = sy[CW-1:0];
    q.del_x = dx[CW-1:0];
    q.del_y = dy[CW-1:0];
    q.cen_x = cx[CW-1:0];
    q.cen_y = cy[CW-1:0];
    q.half_x = hx[HW-1:0];
    q.half_y = hy[HW-1:0];
    return q;
  endfunction

  function automatic longint srand(int span);
    return longint'($urandom_range(2 * span, 0)) - span;
  endfunction

  // segment aimed through or near a box, so most of these reach an edge
  function automatic query_t aimed_query();
    longint cx, cy, hx, hy, sx, sy, dx, dy;
    cx = srand(1 << 20);
    cy = srand(1 << 20);
    hx = $urandom_range(4096, 0);
    hy = $urandom_range(4096, 0);
    if ($urandom_range(9, 0) == 0) hx = 0;
    if ($urandom_range(9, 0) == 0) hy = 0;
    sx = cx + srand(3 * hx + 16);
    sy = cy + srand(3 * hy + 16);
    case ($urandom_range(3, 0))
      0: begin
        dx = 2 * (cx - sx) + srand(hx + 4);
        dy = 2 * (cy - sy) + srand(hy + 4);
      end
      1: begin
        dx = (cx + hx) - sx;
        dy = (cy + hy) - sy;
      end
      2: begin
        dx = 0;
        dy = srand(8 * hy + 16);
      end
      default: begin
        dx = srand(8 * hx + 16);
        dy = ($urandom_range(1, 0) == 1) ? 0 : srand(8 * hy + 16);
      end
    endcase
    return make_query(sx, sy, dx, dy, cx, cy, hx, hy);
  endfunction

  task automatic queue_query(query_t q);
    pending_queries.insert(pending_queries.size(), q);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_queries.size() > 0) begin
        in_tdata <= IN_W'(pending_queries.pop_front());
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(2, 0);
        stall_left <= $urandom_range(200, 20);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(1, 0);
        default: out_tready <= ($urandom_range(4, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && in_tvalid && in_tready) begin
      expected_answers.insert(expected_answers.size(), first_hit(query_t'(in_tdata)));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = answer_t'(out_tdata[20:0]);
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_answers.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.t_hit !== want.t_hit) report_mismatch("hit_time", got.t_hit, want.t_hit);
        if (got.side !== want.side) report_mismatch("side", got.side, want.side);
      end
    end
  end

  initial begin
    longint mx, mn, hmax;
    mx = (longint'(1) << (CW - 1)) - 1;
    mn = -(longint'(1) << (CW - 1));
    hmax = (longint'(1) << HW) - 1;
    // directed: extremes, parallel, degenerate, ties, end hits
    queue_query(make_query(mx, mx, mx, mx, mx, mx, hmax, hmax));
    queue_query(make_query(mn, mn, mn, mn, mn, mn, hmax, hmax));
    queue_query(make_query(mn, mn, mx, mx, 0, 0, hmax, hmax));
    queue_query(make_query(mx, mn, mn, mx, 0, 0, 1, 1));
    queue_query(make_query(0, 0, 0, 0, 0, 0, 256, 256));
    queue_query(make_query(0, -512, 0, 1024, 0, 0, 256, 256));
    queue_query(make_query(0, 512, 0, -1024, 0, 0, 256, 256));
    queue_query(make_query(-512, 0, 1024, 0, 0, 0, 256, 256));
    queue_query(make_query(512, 0, -1024, 0, 0, 0, 256, 256));
    queue_query(make_query(-512, 256, 1024, 0, 0, 0, 256, 256));
    queue_query(make_query(-512, -512, 1024, 1024, 0, 0, 256, 256));
    queue_query(make_query(512, 512, -1024, -1024, 0, 0, 256, 256));
    queue_query(make_query(0, -512, 0, 256, 0, 0, 256, 256));
    queue_query(make_query(0, -512, 0, 255, 0, 0, 256, 256));
    queue_query(make_query(-512, 0, 1024, 0, 0, 0, 0, 256));
    queue_query(make_query(0, -512, 0, 1024, 0, 0, 256, 0));
    queue_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    queue_query(make_query(0, 0, 300, 700, 0, 0, 256, 256));
    queue_query(make_query(-256, 256, 0, 1024, 0, 0, 256, 256));
    queue_query(make_query(257, -512, 0, 1024, 0, 0, 256, 256));
    queue_query(make_query(mx, 0, mn, 0, mn, 0, hmax, 100));
    for (int i = 0; i < NRAND; i++) begin
      if ($urandom_range(9, 0) < 7) begin
        queue_query(aimed_query());
      end else begin
        queue_query(query_t'({$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom}));
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_queries.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("** segment_box_first_hit_unit: PASSED **");
    end else begin
      $display("** segment_box_first_hit_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** segment_box_first_hit_unit: FAILED **");
    $finish;
  end

endmodule
